// ===== rtl/cau_pkg.sv =====
`default_nettype none

package cau_pkg;

    // fixed field widths
    localparam int ROW_W      = 64;
    localparam int GEN_W      = 32;
    localparam int PULSE_W    = 16;
    localparam int RULE_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // default row length
    localparam int CELLS_DEF  = 64;

    // reset values of the configuration registers
    localparam logic [RULE_W-1:0]  RULE_RESET      = 4'd1;
    localparam logic               MODE_RESET      = 1'b1;
    localparam logic [PULSE_W-1:0] PERIOD_RESET    = 16'd0;
    localparam logic [GEN_W-1:0]   SNAP_GEN_RESET  = 32'd1000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RULE_BITS     = 2'd0,
        CFG_NEIGHBOR_MODE = 2'd1,
        CFG_PULSE_PERIOD  = 2'd2,
        CFG_SNAPSHOT_GEN  = 2'd3
    } t_cfg_idx;

    // item opcodes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_opcode;

    // neighbor modes
    localparam logic MODE_SELF_LEFT  = 1'b0;
    localparam logic MODE_LEFT_RIGHT = 1'b1;

    typedef struct packed {
        logic [RULE_W-1:0]  rule_bits;
        logic               neighbor_mode;
        logic [PULSE_W-1:0] pulse_period;
        logic [GEN_W-1:0]   snapshot_gen;
    } t_cfg;

    typedef struct packed {
        logic [GEN_W-1:0]   generation;
        logic [PULSE_W-1:0] pulse_count;
        logic               found;
        logic [GEN_W-1:0]   found_gen;
    } t_ctr;

    typedef struct packed {
        logic [ROW_W-1:0] row_cells;
        logic [GEN_W-1:0] generation_count;
        logic             cycle_found;
        logic [GEN_W-1:0] cycle_generation;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/cau_gen.sv =====
`default_nettype none

module cau_gen #(
    parameter int CELLS = cau_pkg::CELLS_DEF
) (
    input  wire cau_pkg::t_cfg       i_cfg,
    input  wire logic                i_opcode,
    input  wire logic [CELLS-1:0]    i_seed,
    input  wire logic [CELLS-1:0]    i_cells,
    input  wire logic [CELLS-1:0]    i_snapshot,
    input  wire cau_pkg::t_ctr       i_ctr,
    output logic [CELLS-1:0]         o_cells,
    output logic [CELLS-1:0]         o_snapshot,
    output cau_pkg::t_ctr            o_ctr,
    output cau_pkg::t_result         o_result
);

    logic [cau_pkg::GEN_W-1:0]   gen_inc;
    logic [cau_pkg::PULSE_W-1:0] pulse_inc;
    logic                        pulse_hit;
    logic [CELLS-1:0]            prev_row;
    wire logic [CELLS-1:0]       step_row;

    // pulse counter and cell 0 inversion
    assign gen_inc   = i_ctr.generation + 1'b1;
    assign pulse_inc = i_ctr.pulse_count + 1'b1;
    assign pulse_hit = (i_cfg.pulse_period != '0) && (pulse_inc >= i_cfg.pulse_period);

    always_comb begin
        prev_row    = i_cells;
        prev_row[0] = i_cells[0] ^ pulse_hit;
    end

    // cell rule, cells 1 and up in parallel; cell 0 passes through
    assign step_row[0] = prev_row[0];

    for (genvar gi = 1; gi < CELLS; gi++) begin : g_cell
        if (gi == CELLS - 1) begin : g_last
            // last cell is held in the left/right mode
            assign step_row[gi] =
                (i_cfg.neighbor_mode == cau_pkg::MODE_LEFT_RIGHT) ? prev_row[gi] :
                i_cfg.rule_bits[{prev_row[gi], prev_row[gi-1]}];
        end else begin : g_mid
            assign step_row[gi] =
                (i_cfg.neighbor_mode == cau_pkg::MODE_LEFT_RIGHT) ?
                i_cfg.rule_bits[{prev_row[gi-1], prev_row[gi+1]}] :
                i_cfg.rule_bits[{prev_row[gi], prev_row[gi-1]}];
        end
    end

    // next state: load or step with snapshot and cycle check
    always_comb begin
        o_cells    = i_cells;
        o_snapshot = i_snapshot;
        o_ctr      = i_ctr;
        if (i_opcode == cau_pkg::OP_LOAD) begin
            o_cells           = i_seed;
            o_ctr.generation  = '0;
            o_ctr.pulse_count = '0;
            o_ctr.found       = 1'b0;
            o_ctr.found_gen   = '0;
        end else begin
            o_cells          = step_row;
            o_ctr.generation = gen_inc;
            if (pulse_hit || (i_cfg.pulse_period == '0)) begin
                o_ctr.pulse_count = '0;
            end else begin
                o_ctr.pulse_count = pulse_inc;
            end
            if ((gen_inc >= i_cfg.snapshot_gen) && !i_ctr.found) begin
                if (gen_inc == i_cfg.snapshot_gen) begin
                    o_snapshot = step_row;
                end else if (i_snapshot == step_row) begin
                    o_ctr.found     = 1'b1;
                    o_ctr.found_gen = gen_inc;
                end
            end
        end
    end

    // result item, row zero-extended to the port width
    always_comb begin
        o_result                      = '0;
        o_result.row_cells[CELLS-1:0] = o_cells;
        o_result.generation_count     = o_ctr.generation;
        o_result.cycle_found          = o_ctr.found;
        o_result.cycle_generation     = o_ctr.found_gen;
    end

endmodule

`default_nettype wire

// ===== rtl/cau_out_buf.sv =====
`default_nettype none

module cau_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire cau_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output cau_pkg::t_result      o_data,
    input  wire logic             i_stall
);

    logic             r_main_valid;
    logic             r_skid_valid;
    cau_pkg::t_result r_main;
    cau_pkg::t_result r_skid;
    logic             pop;

    assign pop     = r_main_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    // control: main slot and skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/two_input_cellular_automaton_unit.sv =====
`default_nettype none

// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_stall   i_opcode, i_seed_row
// out      output     o_out_valid / i_out_stall o_row_cells, o_generation_count, o_cycle_*
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the output is not stalled; a result passes the
// input register, then one pass of next-row logic into the result buffer, before it
// is valid at the output
// synchronous active-low reset loads configuration defaults, clears row state and all valids
// the result buffer has two slots, so a stalled output holds one finished result
// while the next item still completes; o_in_stall rises only when both are full
// configuration writes are always taken (o_cfg_ready is tied high)

module two_input_cellular_automaton_unit #(
    parameter int CELLS = cau_pkg::CELLS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_opcode,
    input  wire logic [cau_pkg::ROW_W-1:0]        i_seed_row,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [cau_pkg::ROW_W-1:0]             o_row_cells,
    output logic [cau_pkg::GEN_W-1:0]             o_generation_count,
    output logic                                  o_cycle_found,
    output logic [cau_pkg::GEN_W-1:0]             o_cycle_generation,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [cau_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [cau_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    cau_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    logic             r_in_opcode;
    logic [CELLS-1:0] r_in_seed;
    logic [CELLS-1:0] r_cells;
    logic [CELLS-1:0] r_snapshot;
    cau_pkg::t_ctr    r_ctr;

    logic [CELLS-1:0] n_cells;
    logic [CELLS-1:0] n_snapshot;
    cau_pkg::t_ctr    n_ctr;
    cau_pkg::t_result gen_result;
    cau_pkg::t_result out_data;
    logic             buf_full;
    logic             fire;
    logic             in_xfer;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_in_valid && buf_full;
    assign fire        = r_in_valid && !buf_full;
    assign in_xfer     = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rule_bits     <= cau_pkg::RULE_RESET;
            r_cfg.neighbor_mode <= cau_pkg::MODE_RESET;
            r_cfg.pulse_period  <= cau_pkg::PERIOD_RESET;
            r_cfg.snapshot_gen  <= cau_pkg::SNAP_GEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (cau_pkg::t_cfg_idx'(i_cfg_index))
                cau_pkg::CFG_RULE_BITS:
                    r_cfg.rule_bits <= i_cfg_data[cau_pkg::RULE_W-1:0];
                cau_pkg::CFG_NEIGHBOR_MODE:
                    r_cfg.neighbor_mode <= i_cfg_data[0];
                cau_pkg::CFG_PULSE_PERIOD:
                    r_cfg.pulse_period <= i_cfg_data[cau_pkg::PULSE_W-1:0];
                cau_pkg::CFG_SNAPSHOT_GEN:
                    r_cfg.snapshot_gen <= i_cfg_data[cau_pkg::GEN_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_opcode <= i_opcode;
            r_in_seed   <= i_seed_row[CELLS-1:0];
        end
    end

    // next row and counters
    cau_gen #(
        .CELLS (CELLS)
    ) u_gen (
        .i_cfg      (r_cfg),
        .i_opcode   (r_in_opcode),
        .i_seed     (r_in_seed),
        .i_cells    (r_cells),
        .i_snapshot (r_snapshot),
        .i_ctr      (r_ctr),
        .o_cells    (n_cells),
        .o_snapshot (n_snapshot),
        .o_ctr      (n_ctr),
        .o_result   (gen_result)
    );

    // automaton state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells    <= '0;
            r_snapshot <= '0;
            r_ctr      <= '0;
        end else if (fire) begin
            r_cells    <= n_cells;
            r_snapshot <= n_snapshot;
            r_ctr      <= n_ctr;
        end
    end

    // result buffer
    cau_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (gen_result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .i_stall (i_out_stall)
    );

    assign o_row_cells        = out_data.row_cells;
    assign o_generation_count = out_data.generation_count;
    assign o_cycle_found      = out_data.cycle_found;
    assign o_cycle_generation = out_data.cycle_generation;

endmodule

`default_nettype wire
